FILE: hw/rtl/pal_pkg.sv
// shared types and constants for the positional array list unit
// no dependencies; imported by pal_cell and positional_array_list_unit
package pal_pkg;

  // list capacity and derived widths
  localparam int unsigned DEPTH  = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ECNT_W = 6;
  // wide enough for position, count and cell index compares
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MEMBER = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // what a cell loads on the next edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/pal_cell.sv
// one storage cell of the list: holds one word, shifts with its neighbors
// depends on pal_pkg
module pal_cell (
  input  logic                        clk_i,
  input  pal_pkg::cell_ctl_t          ctl_i,
  input  logic [pal_pkg::DATA_W-1:0]  value_i,
  input  logic [pal_pkg::DATA_W-1:0]  left_i,
  input  logic [pal_pkg::DATA_W-1:0]  right_i,
  output logic [pal_pkg::DATA_W-1:0]  data_o,
  output logic                        match_o
);
  import pal_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    case (ctl_i.op)
      CELL_LOAD:  data_d = value_i;
      CELL_LEFT:  data_d = left_i;
      CELL_RIGHT: data_d = right_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  // only cells inside the list take part in a search
  assign match_o = ctl_i.cmp_en & (data_q == value_i);

endmodule

FILE: hw/rtl/positional_array_list_unit.sv
// top level of the positional array list unit: request decode, cell row, result register
// depends on pal_pkg and pal_cell
//
// usage
// - input channel: in_valid_i / in_ready_o carry one request word
//   (req_type_i, position_i, item_value_i); accepted when both are high
// - output channel: out_valid_o / out_ready_i carry one result word
//   (status_o, read_value_o, found_o, entry_count_o, is_empty_o)
// - every request gives exactly one result word
// - the result is registered at the edge that takes the request
// - throughput: one request per cycle while the output is not stalled; the whole
//   row of cells compares in the cycle that takes the request and shifts or loads
//   at its closing edge
// - a result waiting in the output register is replaced in the same edge
//   it is taken, so the input stays ready while out_ready_i is high
// - when the receiver stalls, the output register holds and in_ready_o
//   drops until the word is taken
// - reset clears the entry count and the output valid; cell contents stay
//   undefined until written and are never read before that
module positional_array_list_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pal_pkg::REQ_W-1:0]   req_type_i,
  input  logic [pal_pkg::POS_W-1:0]   position_i,
  input  logic signed [pal_pkg::DATA_W-1:0] item_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pal_pkg::STAT_W-1:0]  status_o,
  output logic signed [pal_pkg::DATA_W-1:0] read_value_o,
  output logic                        found_o,
  output logic [pal_pkg::ECNT_W-1:0]  entry_count_o,
  output logic                        is_empty_o
);
  import pal_pkg::*;

  // handshake
  logic accept;
  logic out_valid_q, out_valid_d;

  // list count
  logic [CNT_W-1:0] count_q, count_d;

  // decode
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pidx;
  logic [IDX_W-1:0] sel_idx;
  logic             list_full;
  logic             ins_bad;
  logic             acc_bad;
  logic             do_insert;
  logic             do_delete;
  logic             do_read;
  logic             do_write;

  // cell row
  cell_ctl_t         cell_ctl   [DEPTH];
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic [DEPTH-1:0]  cell_match;

  // result register
  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] rdval_q, rdval_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  ecnt_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext   = CMP_W'(position_i);
  assign cnt_ext   = CMP_W'(count_q);
  // zero-based target cell; only meaningful when the position is in range
  assign pidx      = pos_ext - CMP_W'(1);
  assign sel_idx   = pidx[IDX_W-1:0];
  assign list_full = (cnt_ext >= CMP_W'(DEPTH));
  // a full list reports full before any position check
  assign ins_bad   = (position_i == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign acc_bad   = (position_i == '0) || (pos_ext > cnt_ext);

  assign do_insert = accept && (req_type_i == REQ_INSERT) && !list_full && !ins_bad;
  assign do_delete = accept && (req_type_i == REQ_DELETE) && !acc_bad;
  assign do_read   = accept && (req_type_i == REQ_READ) && !acc_bad;
  assign do_write  = accept && (req_type_i == REQ_WRITE) && !acc_bad;

  // per-cell control and the row itself
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    always_comb begin
      cell_ctl[k].op     = CELL_HOLD;
      cell_ctl[k].cmp_en = (CMP_W'(k) < cnt_ext);
      if (do_insert) begin
        // open a gap at the target, everything above moves up one cell
        if (CMP_W'(k) == pidx) begin
          cell_ctl[k].op = CELL_LOAD;
        end else if (CMP_W'(k) > pidx) begin
          cell_ctl[k].op = CELL_LEFT;
        end
      end else if (do_delete) begin
        // close the gap, everything from the target up moves down one cell
        if (CMP_W'(k) >= pidx) begin
          cell_ctl[k].op = CELL_RIGHT;
        end
      end else if (do_write) begin
        if (CMP_W'(k) == pidx) begin
          cell_ctl[k].op = CELL_LOAD;
        end
      end
    end

    if (k == 0) begin : g_first
      assign left_w = item_value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_data[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end

    pal_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[k]),
      .value_i (item_value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k]),
      .match_o (cell_match[k])
    );
  end

  // next count
  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_delete) begin
      count_d = count_q - CNT_W'(1);
    end else if (accept && (req_type_i == REQ_CLEAR)) begin
      count_d = '0;
    end
  end

  // result word
  always_comb begin
    status_d = ST_OK;
    case (req_type_i)
      REQ_INSERT: begin
        if (list_full) begin
          status_d = ST_FULL;
        end else if (ins_bad) begin
          status_d = ST_RANGE;
        end
      end
      REQ_DELETE, REQ_READ, REQ_WRITE: begin
        if (acc_bad) begin
          status_d = ST_RANGE;
        end
      end
      default: status_d = ST_OK;
    endcase
    rdval_d = (do_delete || do_read) ? cell_data[sel_idx] : '0;
    found_d = (req_type_i == REQ_MEMBER) && (|cell_match);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      found_q  <= found_d;
      ecnt_q   <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rdval_q;
  assign found_o       = found_q;
  assign entry_count_o = ECNT_W'(ecnt_q);
  assign is_empty_o    = (ecnt_q == '0);

`ifndef SYNTHESIS
  // the count never leaves the capacity of the row
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list count above capacity");

  // insert into a full list is refused with full status and no growth
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_INSERT) && list_full) |=>
      (status_o == ST_FULL) && (count_q == $past(count_q)))
    else $error("insert into full list not refused");

  // a clear leaves an empty list in the result
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_CLEAR)) |=>
      out_valid_o && is_empty_o && (count_q == '0))
    else $error("clear did not empty the list");

  // a stalled result is not overwritten
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(rdval_q) && $stable(ecnt_q)))
    else $error("result changed while stalled");
`endif

endmodule
